>>> rtl/vdlct_pkg.sv
package vdlct_pkg;

  localparam int unsigned MaxDelay    = 32768;
  localparam int unsigned NumChannels = 2;
  localparam int unsigned PtrW        = $clog2(MaxDelay);
  localparam int unsigned ChW         = 1;
  localparam int unsigned AddrW       = ChW + PtrW;
  localparam int unsigned SampleW     = 24;
  localparam int unsigned FracW       = 16;
  localparam int unsigned DelayW      = PtrW + FracW;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned DivNumW     = 33;
  localparam int unsigned AccW        = 44;

  localparam logic [DelayW-1:0] DelayTop = DelayW'((MaxDelay - 1) * (2 ** FracW));

  localparam logic [1:0] OpSample      = 2'd0;
  localparam logic [1:0] OpSetDelay    = 2'd1;
  localparam logic [1:0] OpResetSwitch = 2'd2;

  localparam logic [1:0] ModeInstant   = 2'd0;
  localparam logic [1:0] ModeCrossfade = 2'd1;
  localparam logic [1:0] ModeGlide     = 2'd2;

  localparam logic [1:0] PhaseNormal   = 2'd0;
  localparam logic [1:0] PhaseChanging = 2'd1;
  localparam logic [1:0] PhaseQueued   = 2'd2;

  localparam logic CfgChangeMode = 1'b0;
  localparam logic CfgSwitchTime = 1'b1;

  typedef struct packed {
    logic [1:0]                op;
    logic                      channel;
    logic signed [SampleW-1:0] sample_in;
    logic [PtrW-1:0]           delay_value;
    logic                      frame_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      out_channel;
  } out_word_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [TimeW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [SampleW-1:0] wdata;
    logic               re;
    logic [AddrW-1:0]   raddr;
  } store_req_t;

endpackage

>>> rtl/vdlct_div.sv
module vdlct_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vdlct_pkg::div_req_t req_i,
  output vdlct_pkg::div_rsp_t rsp_o
);
  import vdlct_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [TimeW-1:0]   dsr_q, dsr_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [TimeW:0]     trial;
  logic [TimeW:0]     trial_sub;

  always_comb begin
    trial     = {rem_q, quo_q[DivNumW-1]};
    trial_sub = trial - {1'b0, dsr_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    quo_d     = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial_sub[TimeW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial[TimeW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/vdlct_store.sv
module vdlct_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vdlct_pkg::store_req_t             req_i,
  output logic [vdlct_pkg::SampleW-1:0]     rdata_o,
  output logic                              busy_o
);
  import vdlct_pkg::*;

  logic [SampleW-1:0] mem_q [2 ** AddrW];
  logic [SampleW-1:0] rdata_q;
  logic               clr_q, clr_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

>>> rtl/variable_delay_line_crossfade_tape.sv
// Two-channel audio delay line over one 64K x 24 sample store (32768 words per channel).
// After reset the store is cleared with input stalled; configuration
// writes are taken at any time. A sample word at a steady delay needs one store read;
// during a tape glide four Lagrange weights are built, each followed by a store read
// and a multiply-accumulate, and during a crossfade the word waits for the serial
// divider that forms the fade gain. A glide request also uses the divider.
// A result is held in an output register until taken; the next result waits for it.
module variable_delay_line_crossfade_tape (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  vdlct_pkg::in_word_t          in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output vdlct_pkg::out_word_t         out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [vdlct_pkg::TimeW-1:0]  cfg_data_i
);
  import vdlct_pkg::*;

  localparam int unsigned WtW   = 18;
  localparam int unsigned GSumW = DelayW + 3;
  localparam int unsigned SatW  = AccW - FracW;
  localparam int unsigned P1W   = 34;
  localparam int unsigned P2W   = 52;
  localparam logic [FracW:0]   Unity   = {1'b1, {FracW{1'b0}}};
  localparam logic [P2W-1:0]   L0Bias  = 52'h0_C003_0000_0000;
  localparam logic [P2W-1:0]   L1Half  = 52'h0_0001_0000_0000;
  localparam logic [15:0]      Recip6  = 16'd43691;
  localparam logic signed [WtW-1:0]  L0Off = 18'sd8192;
  localparam logic signed [SatW-1:0] YMax  = SatW'(8388607);
  localparam logic signed [SatW-1:0] YMin  = -SatW'(8388608);

  typedef enum logic [16:0] {
    StIdle  = 17'h00001,
    StDisp  = 17'h00002,
    StSDiv  = 17'h00004,
    StNRead = 17'h00008,
    StNData = 17'h00010,
    StXDiv  = 17'h00020,
    StXRa   = 17'h00040,
    StXRb   = 17'h00080,
    StXMb   = 17'h00100,
    StGStep = 17'h00200,
    StGRnd  = 17'h00400,
    StGPos  = 17'h00800,
    StWa    = 17'h01000,
    StWb    = 17'h02000,
    StWc    = 17'h04000,
    StWd    = 17'h08000,
    StOut   = 17'h10000
  } state_e;

  state_e state_q, state_d;
  in_word_t item_q, item_d;
  logic [1:0]              mode_q;
  logic [TimeW-1:0]        time_q;
  logic [PtrW-1:0]         wp_q, wp_d;
  logic [DelayW-1:0]       cur_q [NumChannels];
  logic [DelayW-1:0]       cur_d [NumChannels];
  logic [PtrW-1:0]         tgt_q [NumChannels];
  logic [PtrW-1:0]         tgt_d [NumChannels];
  logic [PtrW-1:0]         pend_q [NumChannels];
  logic [PtrW-1:0]         pend_d [NumChannels];
  logic [TimeW-1:0]        cnt_q [NumChannels];
  logic [TimeW-1:0]        cnt_d [NumChannels];
  logic [1:0]              phase_q [NumChannels];
  logic [1:0]              phase_d [NumChannels];
  logic signed [31:0]      step_q [NumChannels];
  logic signed [31:0]      step_d [NumChannels];
  logic                    neg_q, neg_d;
  logic [FracW:0]          g_q, g_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    rnd_q, rnd_d;
  logic [PtrW-1:0]         x1_q, x1_d;
  logic [FracW-1:0]        f_q, f_d;
  logic [1:0]              k_q, k_d;
  logic [P1W-1:0]          p1_q, p1_d;
  logic [P2W-1:0]          p2_q, p2_d;
  logic signed [WtW-1:0]   w_q, w_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  div_req_t                div_req;
  div_rsp_t                div_rsp;
  store_req_t              st_req;
  logic [SampleW-1:0]      st_rdata;
  logic                    st_busy;

  logic                    ch;
  logic                    in_acc;
  logic [TimeW-1:0]        eff_time;
  logic signed [DivNumW-1:0] diff_s;
  logic [DivNumW-1:0]      diff_mag;
  logic [31:0]             q32;
  logic signed [GSumW-1:0] gsum;
  logic [DelayW-1:0]       gcur;
  logic [TimeW-1:0]        cnt_dec;
  logic [DelayW:0]         rsum;
  logic [DelayW-1:0]       pos;
  logic [FracW:0]          fac_a, fac_b;
  logic [FracW+1:0]        fac_c;
  logic [P2W-1:0]          l0_num;
  logic [P2W-1:0]          l1_num;
  logic [31:0]             l0_prod;
  logic signed [WtW-1:0]   mac_w;
  logic signed [41:0]      mac_prod;
  logic signed [AccW-1:0]  y_rnd;
  logic signed [SatW-1:0]  y_wide;
  logic signed [SampleW-1:0] y_sat;
  logic                    out_free;

  vdlct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vdlct_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (st_req),
    .rdata_o (st_rdata),
    .busy_o  (st_busy)
  );

  assign in_stall_o  = (state_q != StIdle) || st_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign ch          = item_q.channel;
  assign eff_time    = (time_q == '0) ? TimeW'(1) : time_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    diff_s   = $signed({2'b00, item_q.delay_value, {FracW{1'b0}}})
             - $signed({2'b00, cur_q[ch]});
    diff_mag = diff_s[DivNumW-1] ? DivNumW'(-diff_s) : DivNumW'(diff_s);
    q32      = div_rsp.quotient[31:0];
    gsum     = $signed({3'b000, cur_q[ch]}) + GSumW'(step_q[ch]);
    if (gsum[GSumW-1]) begin
      gcur = '0;
    end else if (gsum > $signed({3'b000, DelayTop})) begin
      gcur = DelayTop;
    end else begin
      gcur = gsum[DelayW-1:0];
    end
    cnt_dec  = cnt_q[ch] - 1'b1;
    rsum     = {1'b0, cur_q[ch]} + (DelayW + 1)'(2 ** (FracW - 1));
    pos      = {wp_q, {FracW{1'b0}}} - cur_q[ch];

    case (k_q)
      2'd0: begin
        fac_a = {1'b0, f_q};
        fac_b = Unity - {1'b0, f_q};
        fac_c = {Unity, 1'b0} - {2'b00, f_q};
      end
      2'd1: begin
        fac_a = Unity + {1'b0, f_q};
        fac_b = Unity - {1'b0, f_q};
        fac_c = {Unity, 1'b0} - {2'b00, f_q};
      end
      2'd2: begin
        fac_a = Unity + {1'b0, f_q};
        fac_b = {1'b0, f_q};
        fac_c = {Unity, 1'b0} - {2'b00, f_q};
      end
      default: begin
        fac_a = Unity + {1'b0, f_q};
        fac_b = {1'b0, f_q};
        fac_c = {1'b0, Unity} - {2'b00, f_q};
      end
    endcase

    l0_num  = L0Bias - p2_q;
    l1_num  = p2_q + L1Half;
    l0_prod = l0_num[47:32] * Recip6;

    case (state_q)
      StXRb:   mac_w = $signed({1'b0, g_q});
      StXMb:   mac_w = $signed({1'b0, Unity - g_q});
      default: mac_w = w_q;
    endcase
    mac_prod = mac_w * $signed(st_rdata);

    y_rnd  = acc_q + AccW'(2 ** (FracW - 1));
    y_wide = $signed(y_rnd[AccW-1:FracW]);
    if (y_wide > YMax) begin
      y_sat = YMax[SampleW-1:0];
    end else if (y_wide < YMin) begin
      y_sat = YMin[SampleW-1:0];
    end else begin
      y_sat = y_wide[SampleW-1:0];
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.divisor  = eff_time;
    div_req.dividend = diff_mag;
    if (item_q.op == OpSample) begin
      div_req.dividend = {1'b0, cnt_q[ch], {FracW{1'b0}}} + DivNumW'(eff_time >> 1);
    end
    if (state_q == StDisp) begin
      if (item_q.op == OpSample) begin
        div_req.start = (phase_q[ch] != PhaseNormal) && (mode_q == ModeCrossfade);
      end else if (item_q.op == OpSetDelay) begin
        div_req.start = (mode_q == ModeGlide);
      end
    end
  end

  always_comb begin
    st_req.we    = (state_q == StDisp) && (item_q.op == OpSample);
    st_req.waddr = {ch, wp_q};
    st_req.wdata = item_q.sample_in;
    st_req.re    = 1'b0;
    st_req.raddr = {ch, wp_q - cur_q[ch][DelayW-1:FracW]};
    case (state_q)
      StNRead, StXRa: begin
        st_req.re = 1'b1;
      end
      StXRb: begin
        st_req.re    = 1'b1;
        st_req.raddr = {ch, wp_q - tgt_q[ch]};
      end
      StWc: begin
        st_req.re    = 1'b1;
        st_req.raddr = {ch, x1_q + PtrW'(k_q) - PtrW'(1)};
      end
      default: begin
        st_req.re = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    wp_d        = wp_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    step_d      = step_q;
    neg_d       = neg_q;
    g_d         = g_q;
    acc_d       = acc_q;
    rnd_d       = rnd_q;
    x1_d        = x1_q;
    f_d         = f_q;
    k_d         = k_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    w_d         = w_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          item_d  = in_word_i;
          state_d = StDisp;
        end
      end
      StDisp: begin
        state_d = StIdle;
        case (item_q.op)
          OpSample: begin
            if (phase_q[ch] == PhaseNormal) begin
              state_d = StNRead;
            end else if (mode_q == ModeCrossfade) begin
              state_d = StXDiv;
            end else begin
              state_d = StGStep;
            end
          end
          OpSetDelay: begin
            case (mode_q)
              ModeInstant: begin
                cur_d[ch] = {item_q.delay_value, {FracW{1'b0}}};
              end
              ModeCrossfade: begin
                if (phase_q[ch] == PhaseNormal) begin
                  phase_d[ch] = PhaseChanging;
                  tgt_d[ch]   = item_q.delay_value;
                  cnt_d[ch]   = eff_time;
                end else begin
                  phase_d[ch] = PhaseQueued;
                  pend_d[ch]  = item_q.delay_value;
                end
              end
              ModeGlide: begin
                neg_d   = diff_s[DivNumW-1];
                state_d = StSDiv;
              end
              default: begin
                state_d = StIdle;
              end
            endcase
          end
          OpResetSwitch: begin
            for (int c = 0; c < NumChannels; c++) begin
              if (phase_q[c] == PhaseChanging) begin
                cur_d[c] = {tgt_q[c], {FracW{1'b0}}};
              end else if (phase_q[c] == PhaseQueued) begin
                cur_d[c] = {pend_q[c], {FracW{1'b0}}};
              end
              cnt_d[c]   = '0;
              tgt_d[c]   = '0;
              pend_d[c]  = '0;
              phase_d[c] = PhaseNormal;
            end
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StSDiv: begin
        if (div_rsp.done) begin
          step_d[ch]  = neg_q ? -$signed(q32) : $signed(q32);
          phase_d[ch] = PhaseChanging;
          cnt_d[ch]   = eff_time;
          tgt_d[ch]   = item_q.delay_value;
          state_d     = StIdle;
        end
      end
      StNRead: begin
        state_d = StNData;
      end
      StNData: begin
        acc_d   = AccW'($signed(st_rdata)) <<< FracW;
        state_d = StOut;
      end
      StXDiv: begin
        if (div_rsp.done) begin
          g_d     = (div_rsp.quotient > DivNumW'(Unity)) ? Unity
                  : div_rsp.quotient[FracW:0];
          state_d = StXRa;
        end
      end
      StXRa: begin
        state_d = StXRb;
      end
      StXRb: begin
        acc_d   = AccW'(mac_prod);
        state_d = StXMb;
      end
      StXMb: begin
        acc_d     = acc_q + AccW'(mac_prod);
        cnt_d[ch] = cnt_dec;
        if (cnt_dec == '0) begin
          cur_d[ch] = {tgt_q[ch], {FracW{1'b0}}};
          if (phase_q[ch] == PhaseChanging) begin
            phase_d[ch] = PhaseNormal;
          end else begin
            phase_d[ch] = PhaseChanging;
            cnt_d[ch]   = eff_time;
            tgt_d[ch]   = pend_q[ch];
          end
        end
        state_d = StOut;
      end
      StGStep: begin
        cur_d[ch] = gcur;
        cnt_d[ch] = cnt_dec;
        rnd_d     = (cnt_dec == '0);
        if (cnt_dec == '0) begin
          phase_d[ch] = PhaseNormal;
        end
        state_d = StGRnd;
      end
      StGRnd: begin
        if (rnd_q) begin
          if (rsum[DelayW]) begin
            cur_d[ch] = DelayTop;
          end else begin
            cur_d[ch] = {rsum[DelayW-1:FracW], {FracW{1'b0}}};
          end
        end
        state_d = StGPos;
      end
      StGPos: begin
        x1_d    = pos[DelayW-1:FracW];
        f_d     = pos[FracW-1:0];
        k_d     = '0;
        acc_d   = '0;
        state_d = StWa;
      end
      StWa: begin
        p1_d    = fac_a * fac_b;
        state_d = StWb;
      end
      StWb: begin
        p2_d    = p1_q * fac_c;
        state_d = StWc;
      end
      StWc: begin
        if ((k_q == 2'd0) || (k_q == 2'd3)) begin
          w_d = $signed(WtW'(l0_prod[31:18])) - L0Off;
        end else begin
          w_d = $signed({1'b0, l1_num[49:33]});
        end
        state_d = StWd;
      end
      StWd: begin
        acc_d = acc_q + AccW'(mac_prod);
        k_d   = k_q + 1'b1;
        if (k_q == 2'd3) begin
          state_d = StOut;
        end else begin
          state_d = StWa;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_word_d.sample_out  = y_sat;
          out_word_d.out_channel = ch;
          if (item_q.frame_end) begin
            wp_d = wp_q + 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= ModeInstant;
      time_q      <= TimeW'(4800);
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumChannels; c++) begin
        cur_q[c]   <= '0;
        tgt_q[c]   <= '0;
        pend_q[c]  <= '0;
        cnt_q[c]   <= '0;
        phase_q[c] <= PhaseNormal;
        step_q[c]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgChangeMode) begin
          mode_q <= cfg_data_i[1:0];
        end else begin
          time_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    neg_q      <= neg_d;
    g_q        <= g_d;
    acc_q      <= acc_d;
    rnd_q      <= rnd_d;
    x1_q       <= x1_d;
    f_q        <= f_d;
    k_q        <= k_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    w_q        <= w_d;
    out_word_q <= out_word_d;
  end

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StXDiv) || (state_q == StSDiv))
    else $error("divider result arrived with no consumer");

  a_delay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q[0] <= DelayTop) && (cur_q[1] <= DelayTop))
    else $error("current delay beyond store depth");

  a_wp_moves_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StOut) |=> $stable(wp_q))
    else $error("write pointer moved outside result delivery");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[0] <= PhaseQueued) && (phase_q[1] <= PhaseQueued))
    else $error("illegal change phase");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_busy |-> !in_acc && (state_q == StIdle))
    else $error("word accepted during store clear");

endmodule
